[design/bqma_pkg.sv]
// bqma_pkg: shared types, codes and constants for the biquad / moving-average filter
// no dependencies; imported by every module of the block
package bqma_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int COEF_W         = 18;
  localparam int FRAC_W         = 16;
  localparam int MODE_W         = 2;
  localparam int WLEN_W         = 6;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 18;
  localparam int BQ_ORDER       = 2;
  localparam int MAX_WINDOW_DEF = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_MA     = 2'd0,
    MODE_BQ     = 2'd1,
    MODE_BYPASS = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE = 3'd0,
    REG_WLEN = 3'd1,
    REG_B0   = 3'd2,
    REG_A1   = 3'd3,
    REG_A2   = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    CMD_FILTER = 1'b0,
    CMD_CLEAR  = 1'b1
  } cmd_t;

  // what an accepted beat does once decoded against mode and fill count
  typedef enum logic [2:0] {
    K_CLEAR   = 3'd0,
    K_PASS    = 3'd1,
    K_MA_WARM = 3'd2,
    K_MA_RUN  = 3'd3,
    K_BQ_WARM = 3'd4,
    K_BQ_RUN  = 3'd5
  } kind_t;

  localparam logic [MODE_W-1:0]        MODE_RESET = MODE_BYPASS;
  localparam logic [WLEN_W-1:0]        WLEN_RESET = WLEN_W'(1);
  localparam logic signed [COEF_W-1:0] B0_RESET   = COEF_W'(65536);
  localparam logic signed [COEF_W-1:0] A_RESET    = '0;

  typedef struct packed {
    logic                       cmd;
    logic signed [SAMPLE_W-1:0] sample;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       warming;
  } out_t;

  // decoded beat handed from the front end to the arithmetic pipe
  typedef struct packed {
    kind_t                      kind;
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] x1;
    logic signed [SAMPLE_W-1:0] x2;
    logic signed [SAMPLE_W-1:0] old;
  } s1_t;

endpackage

[design/biquad_or_moving_average_filter.sv]
// an accepted beat runs through the s1, s2, s3 and output registers to out_
// throughput: one beat per clock unless out_ready stalls; the limit is the biquad
//   feedback stage: a1*y1 + a2*y2 of the previous result is formed and saturated
// reset: synchronous, active low; clears pipeline valids, fill count, write slot,
//   window sum and loads register defaults; the history memory is not cleared
module biquad_or_moving_average_filter #(
  parameter int MAX_WINDOW = bqma_pkg::MAX_WINDOW_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bqma_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bqma_pkg::out_t                    out_data,
  input  logic                              cfg_we,
  input  logic [bqma_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bqma_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import bqma_pkg::*;

  logic [MODE_W-1:0]        mode_r;
  logic [WLEN_W-1:0]        wlen_r;
  logic signed [COEF_W-1:0] b0_r, a1_r, a2_r;
  logic                     hist_clr;
  logic                     s1_valid, s1_take;
  s1_t                      s1_data;

  // a mode or window write restarts the history
  assign hist_clr = cfg_we && (cfg_index == REG_MODE || cfg_index == REG_WLEN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RESET;
      wlen_r <= WLEN_RESET;
      b0_r   <= B0_RESET;
      a1_r   <= A_RESET;
      a2_r   <= A_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE: mode_r <= cfg_wdata[MODE_W-1:0];
        REG_WLEN: wlen_r <= cfg_wdata[WLEN_W-1:0];
        REG_B0:   b0_r   <= cfg_wdata;
        REG_A1:   a1_r   <= cfg_wdata;
        REG_A2:   a2_r   <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  bqma_front #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .mode       (mode_r),
    .window_len (wlen_r),
    .hist_clr   (hist_clr),
    .s1_take    (s1_take),
    .s1_valid   (s1_valid),
    .s1_data    (s1_data)
  );

  bqma_mac #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_data   (s1_data),
    .s1_take   (s1_take),
    .hist_clr  (hist_clr),
    .b0        (b0_r),
    .a1        (a1_r),
    .a2        (a2_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[design/bqma_front.sv]
// bqma_front: beat decode, fill count, write slot and the sample history memory
// depends on bqma_pkg; feeds bqma_mac through one registered stage
module bqma_front #(
  parameter int MAX_WINDOW = bqma_pkg::MAX_WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bqma_pkg::in_t                 in_data,
  input  logic [bqma_pkg::MODE_W-1:0]   mode,
  input  logic [bqma_pkg::WLEN_W-1:0]   window_len,
  input  logic                          hist_clr,
  input  logic                          s1_take,
  output logic                          s1_valid,
  output bqma_pkg::s1_t                 s1_data
);
  import bqma_pkg::*;

  localparam int ADDR_W = $clog2(MAX_WINDOW);
  localparam int FILL_W = $clog2(MAX_WINDOW > BQ_ORDER ? MAX_WINDOW : BQ_ORDER + 1);
  localparam int WLC_W  = $clog2(MAX_WINDOW + 1);
  localparam int EXT_W  = (WLEN_W > WLC_W) ? WLEN_W : WLC_W;
  localparam logic [EXT_W-1:0]  MW_EXT   = EXT_W'(MAX_WINDOW);
  localparam logic [ADDR_W:0]   MW_A     = (ADDR_W + 1)'(MAX_WINDOW);
  localparam logic [ADDR_W-1:0] SLOT_TOP = ADDR_W'(MAX_WINDOW - 1);

  logic signed [SAMPLE_W-1:0] hist_mem [MAX_WINDOW];
  logic signed [SAMPLE_W-1:0] rd_data_r;

  logic [ADDR_W-1:0]          wslot_r, wslot_nxt;
  logic [FILL_W-1:0]          fill_r, fill_nxt;
  logic signed [SAMPLE_W-1:0] x1_r, x1_nxt, x2_r, x2_nxt;
  logic                       s1_v_r, s1_v_nxt;
  kind_t                      s1_kind_r;
  logic signed [SAMPLE_W-1:0] s1_x_r, s1_x1_r, s1_x2_r;

  logic              accept;
  logic [EXT_W-1:0]  wl_ext, wl_clamp, order;
  logic [ADDR_W:0]   rd_sum;
  logic [ADDR_W-1:0] rd_addr;
  kind_t             dec_kind;
  logic              dec_push;
  logic [FILL_W-1:0] dec_fill;

  assign in_ready = !s1_v_r || s1_take;
  assign accept   = in_valid && in_ready;

  // window length of zero acts as one, above the store depth as the depth
  always_comb begin
    wl_ext = EXT_W'(window_len);
    if (wl_ext == '0) begin
      wl_clamp = EXT_W'(1);
    end else if (wl_ext > MW_EXT) begin
      wl_clamp = MW_EXT;
    end else begin
      wl_clamp = wl_ext;
    end
    order = wl_clamp - EXT_W'(1);
  end

  always_comb begin
    dec_kind = K_PASS;
    dec_push = 1'b0;
    dec_fill = fill_r;
    if (in_data.cmd == CMD_CLEAR) begin
      dec_kind = K_CLEAR;
      dec_fill = '0;
    end else begin
      unique case (mode)
        MODE_MA: begin
          if (order != '0) begin
            dec_push = 1'b1;
            if (EXT_W'(fill_r) < order) begin
              dec_kind = K_MA_WARM;
              dec_fill = fill_r + 1'b1;
            end else begin
              dec_kind = K_MA_RUN;
            end
          end
        end
        MODE_BQ: begin
          dec_push = 1'b1;
          if (fill_r < FILL_W'(BQ_ORDER)) begin
            dec_kind = K_BQ_WARM;
            dec_fill = fill_r + 1'b1;
          end else begin
            dec_kind = K_BQ_RUN;
          end
        end
        default: ;
      endcase
    end
  end

  // oldest sample of the window sits order slots behind the write slot
  always_comb begin
    rd_sum = {1'b0, wslot_r} + MW_A - (ADDR_W + 1)'(order);
    if (rd_sum >= MW_A) begin
      rd_addr = ADDR_W'(rd_sum - MW_A);
    end else begin
      rd_addr = ADDR_W'(rd_sum);
    end
  end

  always_comb begin
    wslot_nxt = wslot_r;
    fill_nxt  = fill_r;
    x1_nxt    = x1_r;
    x2_nxt    = x2_r;
    s1_v_nxt  = s1_v_r;
    if (s1_take) begin
      s1_v_nxt = 1'b0;
    end
    if (accept) begin
      s1_v_nxt = 1'b1;
      fill_nxt = dec_fill;
      if (dec_push) begin
        wslot_nxt = (wslot_r == SLOT_TOP) ? '0 : wslot_r + 1'b1;
        x1_nxt    = in_data.sample;
        x2_nxt    = x1_r;
      end
    end
    if (hist_clr) begin
      fill_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wslot_r <= '0;
      fill_r  <= '0;
      s1_v_r  <= 1'b0;
    end else begin
      wslot_r <= wslot_nxt;
      fill_r  <= fill_nxt;
      s1_v_r  <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x1_r <= x1_nxt;
    x2_r <= x2_nxt;
    if (accept) begin
      s1_kind_r <= dec_kind;
      s1_x_r    <= in_data.sample;
      s1_x1_r   <= x1_r;
      s1_x2_r   <= x2_r;
    end
  end

  // read and write slots differ unless order is zero; a write shows next cycle
  always_ff @(posedge clk) begin
    if (accept && dec_push) begin
      hist_mem[wslot_r] <= in_data.sample;
    end
    if (accept) begin
      rd_data_r <= hist_mem[rd_addr];
    end
  end

  assign s1_valid = s1_v_r;
  assign s1_data  = '{kind: s1_kind_r, x: s1_x_r, x1: s1_x1_r, x2: s1_x2_r, old: rd_data_r};

endmodule

[design/bqma_mac.sv]
// bqma_mac: running window sum, feed-forward multiply, feedback stage and output register
// depends on bqma_pkg; takes decoded beats from bqma_front
module bqma_mac #(
  parameter int MAX_WINDOW = bqma_pkg::MAX_WINDOW_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                s1_valid,
  input  bqma_pkg::s1_t                       s1_data,
  output logic                                s1_take,
  input  logic                                hist_clr,
  input  logic signed [bqma_pkg::COEF_W-1:0]  b0,
  input  logic signed [bqma_pkg::COEF_W-1:0]  a1,
  input  logic signed [bqma_pkg::COEF_W-1:0]  a2,
  output logic                                out_valid,
  input  logic                                out_ready,
  output bqma_pkg::out_t                      out_data
);
  import bqma_pkg::*;

  localparam int SUM_W  = SAMPLE_W + $clog2(MAX_WINDOW);
  localparam int OP_W   = (SUM_W > SAMPLE_W + 2) ? SUM_W : SAMPLE_W + 2;
  localparam int PROD_W = COEF_W + OP_W;
  localparam int FB_W   = COEF_W + SAMPLE_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2 ** (SAMPLE_W - 1) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-(2 ** (SAMPLE_W - 1)));

  logic en2, en3, en_out;

  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic signed [SUM_W-1:0] x_s, old_s;
  logic signed [OP_W-1:0]  op_nxt;

  logic                     s2_v_r, s2_v_nxt;
  kind_t                    s2_kind_r;
  logic signed [SAMPLE_W-1:0] s2_x_r;
  logic signed [OP_W-1:0]   s2_op_r;
  logic signed [PROD_W-1:0] prod;

  logic                     s3_v_r, s3_v_nxt;
  kind_t                    s3_kind_r;
  logic signed [SAMPLE_W-1:0] s3_x_r;
  logic signed [PROD_W-1:0] s3_prod_r;

  logic signed [SAMPLE_W-1:0] y1_r, y2_r;
  logic signed [FB_W-1:0]   fb1, fb2;
  logic signed [ACC_W-1:0]  acc, acc_fl;
  logic signed [SAMPLE_W-1:0] y_sat, y_sel;
  logic                     warm_sel;
  logic                     is_bq;

  logic  out_v_r, out_v_nxt;
  out_t  out_data_r;

  // each stage moves when the one after it is empty or moving
  assign en_out  = !out_v_r || out_ready;
  assign en3     = !s3_v_r || en_out;
  assign en2     = !s2_v_r || en3;
  assign s1_take = s1_valid && en2;

  assign x_s   = SUM_W'(s1_data.x);
  assign old_s = SUM_W'(s1_data.old);

  always_comb begin
    sum_nxt = sum_r;
    if (s1_take) begin
      case (s1_data.kind)
        K_CLEAR:   sum_nxt = '0;
        K_MA_WARM: sum_nxt = sum_r + x_s;
        K_MA_RUN:  sum_nxt = sum_r + x_s - old_s;
        default:   ;
      endcase
    end
    if (hist_clr) begin
      sum_nxt = '0;
    end
  end

  // multiplier operand: x plus window sum, or the binomial x + 2*x1 + x2
  always_comb begin
    if (s1_data.kind == K_MA_RUN) begin
      op_nxt = OP_W'(sum_r) + OP_W'(s1_data.x);
    end else begin
      op_nxt = OP_W'(s1_data.x) + (OP_W'(s1_data.x1) <<< 1) + OP_W'(s1_data.x2);
    end
  end

  assign s2_v_nxt = en2 ? s1_valid : s2_v_r;
  assign s3_v_nxt = en3 ? s2_v_r : s3_v_r;
  assign out_v_nxt = en_out ? s3_v_r : out_v_r;

  assign prod = PROD_W'(b0) * PROD_W'(s2_op_r);

  // feedback closes here: y1 of this beat is the previous biquad result
  assign fb1   = FB_W'(a1) * FB_W'(y1_r);
  assign fb2   = FB_W'(a2) * FB_W'(y2_r);
  assign is_bq = (s3_kind_r == K_BQ_RUN);

  always_comb begin
    acc = ACC_W'(s3_prod_r);
    if (is_bq) begin
      acc = ACC_W'(s3_prod_r) - ACC_W'(fb1) - ACC_W'(fb2);
    end
    acc_fl = acc >>> FRAC_W;
    if (acc_fl > SAT_HI) begin
      y_sat = SAMPLE_W'(SAT_HI);
    end else if (acc_fl < SAT_LO) begin
      y_sat = SAMPLE_W'(SAT_LO);
    end else begin
      y_sat = SAMPLE_W'(acc_fl);
    end
  end

  always_comb begin
    case (s3_kind_r) inside
      K_CLEAR: begin
        y_sel    = '0;
        warm_sel = 1'b0;
      end
      K_MA_WARM, K_BQ_WARM: begin
        y_sel    = s3_x_r;
        warm_sel = 1'b1;
      end
      K_MA_RUN, K_BQ_RUN: begin
        y_sel    = y_sat;
        warm_sel = 1'b0;
      end
      default: begin
        y_sel    = s3_x_r;
        warm_sel = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      sum_r   <= sum_nxt;
      s2_v_r  <= s2_v_nxt;
      s3_v_r  <= s3_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s2_kind_r <= s1_data.kind;
      s2_x_r    <= s1_data.x;
      s2_op_r   <= op_nxt;
    end
    if (en3 && s2_v_r) begin
      s3_kind_r <= s2_kind_r;
      s3_x_r    <= s2_x_r;
      s3_prod_r <= prod;
    end
    if (en_out && s3_v_r) begin
      out_data_r <= '{filtered: y_sel, warming: warm_sel};
      if (s3_kind_r == K_BQ_WARM || s3_kind_r == K_BQ_RUN) begin
        y1_r <= y_sel;
        y2_r <= y1_r;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

endmodule

[design/bqma_checker.sv]
// bqma_checker: port-level assertions for the filter, bound to the top level
// depends on bqma_pkg; watches only the top-level ports
module bqma_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input bqma_pkg::in_t   in_data,
  input logic            out_valid,
  input logic            out_ready,
  input bqma_pkg::out_t  out_data
);
  import bqma_pkg::*;

  localparam logic [2:0] MAX_INFLIGHT = 3'd4;
  localparam int         EMPTY_LAT    = 4;

  logic       in_fire, out_fire;
  logic [2:0] inflight_r, inflight_nxt;

  assign in_fire      = in_valid && in_ready;
  assign out_fire     = out_valid && out_ready;
  assign inflight_nxt = inflight_r + 3'(in_fire) - 3'(out_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed or dropped while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != '0)
    else $error("result beat with no beat accepted");

  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= MAX_INFLIGHT)
    else $error("more beats in flight than pipeline stages");

  // clear through an empty pipe: zero result with warming low
  a_clear_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && inflight_r == '0 && in_data.cmd == CMD_CLEAR |->
      ##EMPTY_LAT (out_valid && out_data.filtered == '0 && !out_data.warming))
    else $error("clear beat result wrong or late");

endmodule

bind biquad_or_moving_average_filter bqma_checker u_bqma_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
